// ===== rtl/rmfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmfp_pkg: shared types and constants of the RPC metadata frame parser
// Holds the parse phases, field tags, error codes, register indexes and the
// item types that travel between the queue and the parser back end.
// ----------------------------------------------------------------------------
package rmfp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 88;

  localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_STATUS = 2'd1;

  localparam logic       BIG_ENDIAN_RESET = 1'b1;
  localparam logic [7:0] MAX_STATUS_RESET = 8'd4;

  localparam logic [2:0] TAG_LENGTH   = 3'd0;
  localparam logic [2:0] TAG_SERVICE  = 3'd1;
  localparam logic [2:0] TAG_METHOD   = 3'd2;
  localparam logic [2:0] TAG_STATUS   = 3'd3;
  localparam logic [2:0] TAG_ERR_TEXT = 3'd4;
  localparam logic [2:0] TAG_DEADLINE = 3'd5;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SERVICE  = 3'd1;
  localparam logic [2:0] ERR_METHOD   = 3'd2;
  localparam logic [2:0] ERR_STATUS   = 3'd3;
  localparam logic [2:0] ERR_ERR_TEXT = 3'd4;
  localparam logic [2:0] ERR_DEADLINE = 3'd5;
  localparam logic [2:0] ERR_TRAILING = 3'd6;

  localparam logic [2:0] INT32_LAST_BYTE = 3'd3;
  localparam logic [2:0] INT64_LAST_BYTE = 3'd7;

  typedef enum logic [3:0] {
    PH_SVC_LEN  = 4'd0,
    PH_SVC_BODY = 4'd1,
    PH_MTH_LEN  = 4'd2,
    PH_MTH_BODY = 4'd3,
    PH_STATUS   = 4'd4,
    PH_ERR_LEN  = 4'd5,
    PH_ERR_BODY = 4'd6,
    PH_DEADLINE = 4'd7,
    PH_DONE     = 4'd8,
    PH_HALT     = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic       big_endian;
    logic [7:0] max_status;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  field_tag;
    logic        frame_done;
    logic [2:0]  error_code;
    logic [7:0]  status_value;
    logic [63:0] deadline_value;
  } out_item_t;

  function automatic logic [31:0] take32(input logic [31:0] acc, input logic [7:0] b,
                                         input logic be, input logic [1:0] pos);
    logic [31:0] r;
    if (be) begin
      r = {acc[23:0], b};
    end else begin
      r = acc | ({24'd0, b} << {pos, 3'b000});
    end
    return r;
  endfunction

  function automatic logic [2:0] trunc_code(input phase_t ph);
    logic [2:0] r;
    case (ph)
      PH_SVC_LEN, PH_SVC_BODY: r = ERR_SERVICE;
      PH_MTH_LEN, PH_MTH_BODY: r = ERR_METHOD;
      PH_STATUS:               r = ERR_STATUS;
      PH_ERR_LEN, PH_ERR_BODY: r = ERR_ERR_TEXT;
      PH_DEADLINE:             r = ERR_DEADLINE;
      default:                 r = ERR_NONE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rmfp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmfp_queue: request queue between the front and the parser back end
// A small register queue that lets the input side and the parser stall
// independently.
// ----------------------------------------------------------------------------
module rmfp_queue #(
  parameter int unsigned DEPTH = rmfp_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire rmfp_pkg::in_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output rmfp_pkg::in_item_t      head_item,
  output logic                    empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rmfp_pkg::in_item_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rmfp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmfp_back: parser back end of the RPC metadata frame parser
// Walks the frame phases one byte per cycle unless the result stalls, decodes
// lengths, status, deadline; holds the sticky first error and result register.
// ----------------------------------------------------------------------------
module rmfp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rmfp_pkg::cfg_t      cfg,
  input  wire logic                item_avail,
  input  wire rmfp_pkg::in_item_t  item,
  output logic                     item_take,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output rmfp_pkg::out_item_t      res
);

  rmfp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [2:0]  shift_r, shift_nxt;
  logic [31:0] status_acc_r, status_acc_nxt;
  logic [63:0] deadline_acc_r, deadline_acc_nxt;
  logic [2:0]  first_error_r, first_error_nxt;
  logic        res_valid_r, res_valid_nxt;
  rmfp_pkg::out_item_t res_r, res_nxt;
  logic [31:0] len_val;
  logic [2:0]  err_out;

  assign item_take = item_avail && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    shift_nxt        = shift_r;
    status_acc_nxt   = status_acc_r;
    deadline_acc_nxt = deadline_acc_r;
    first_error_nxt  = first_error_r;
    res_valid_nxt    = res_valid_r && !res_ready;
    res_nxt          = res_r;
    len_val          = rmfp_pkg::take32(bytes_left_r, item.data_byte, cfg.big_endian,
                                        shift_r[1:0]);
    err_out          = rmfp_pkg::ERR_NONE;

    res_nxt.field_tag = rmfp_pkg::TAG_LENGTH;
    if (item.byte_valid) begin
      case (phase_r)
        rmfp_pkg::PH_SVC_LEN, rmfp_pkg::PH_MTH_LEN, rmfp_pkg::PH_ERR_LEN: begin
          bytes_left_nxt = len_val;
          if (shift_r == rmfp_pkg::INT32_LAST_BYTE) begin
            shift_nxt = '0;
            case (phase_r)
              rmfp_pkg::PH_SVC_LEN: begin
                phase_nxt = (len_val != '0) ? rmfp_pkg::PH_SVC_BODY : rmfp_pkg::PH_MTH_LEN;
              end
              rmfp_pkg::PH_MTH_LEN: begin
                phase_nxt = (len_val != '0) ? rmfp_pkg::PH_MTH_BODY : rmfp_pkg::PH_STATUS;
              end
              default: begin
                phase_nxt = (len_val != '0) ? rmfp_pkg::PH_ERR_BODY : rmfp_pkg::PH_DEADLINE;
              end
            endcase
          end else begin
            shift_nxt = shift_r + 1'b1;
          end
        end
        rmfp_pkg::PH_SVC_BODY, rmfp_pkg::PH_MTH_BODY, rmfp_pkg::PH_ERR_BODY: begin
          bytes_left_nxt = bytes_left_r - 1'b1;
          case (phase_r)
            rmfp_pkg::PH_SVC_BODY: begin
              res_nxt.field_tag = rmfp_pkg::TAG_SERVICE;
              if (bytes_left_nxt == '0) begin
                phase_nxt = rmfp_pkg::PH_MTH_LEN;
              end
            end
            rmfp_pkg::PH_MTH_BODY: begin
              res_nxt.field_tag = rmfp_pkg::TAG_METHOD;
              if (bytes_left_nxt == '0) begin
                phase_nxt = rmfp_pkg::PH_STATUS;
              end
            end
            default: begin
              res_nxt.field_tag = rmfp_pkg::TAG_ERR_TEXT;
              if (bytes_left_nxt == '0) begin
                phase_nxt = rmfp_pkg::PH_DEADLINE;
              end
            end
          endcase
        end
        rmfp_pkg::PH_STATUS: begin
          res_nxt.field_tag = rmfp_pkg::TAG_STATUS;
          status_acc_nxt = rmfp_pkg::take32(status_acc_r, item.data_byte, cfg.big_endian,
                                            shift_r[1:0]);
          if (shift_r == rmfp_pkg::INT32_LAST_BYTE) begin
            shift_nxt = '0;
            if (status_acc_nxt > {24'd0, cfg.max_status}) begin
              first_error_nxt = rmfp_pkg::ERR_STATUS;
              phase_nxt       = rmfp_pkg::PH_HALT;
            end else begin
              phase_nxt = rmfp_pkg::PH_ERR_LEN;
            end
          end else begin
            shift_nxt = shift_r + 1'b1;
          end
        end
        rmfp_pkg::PH_DEADLINE: begin
          res_nxt.field_tag = rmfp_pkg::TAG_DEADLINE;
          if (cfg.big_endian) begin
            deadline_acc_nxt = {deadline_acc_r[55:0], item.data_byte};
          end else begin
            deadline_acc_nxt = deadline_acc_r | ({56'd0, item.data_byte} << {shift_r, 3'b000});
          end
          if (shift_r == rmfp_pkg::INT64_LAST_BYTE) begin
            shift_nxt = '0;
            phase_nxt = rmfp_pkg::PH_DONE;
          end else begin
            shift_nxt = shift_r + 1'b1;
          end
        end
        rmfp_pkg::PH_DONE: begin
          first_error_nxt = rmfp_pkg::ERR_TRAILING;
          phase_nxt       = rmfp_pkg::PH_HALT;
        end
        default: begin
          phase_nxt = rmfp_pkg::PH_HALT;
        end
      endcase
    end

    res_nxt.out_byte       = item.byte_valid ? item.data_byte : 8'd0;
    res_nxt.frame_done     = item.frame_end;
    res_nxt.status_value   = '0;
    res_nxt.deadline_value = '0;
    if (item.frame_end) begin
      err_out = (first_error_nxt == rmfp_pkg::ERR_NONE) ? rmfp_pkg::trunc_code(phase_nxt)
                                                          : first_error_nxt;
      if (err_out == rmfp_pkg::ERR_NONE) begin
        res_nxt.status_value   = status_acc_nxt[7:0];
        res_nxt.deadline_value = deadline_acc_nxt;
      end
      phase_nxt        = rmfp_pkg::PH_SVC_LEN;
      bytes_left_nxt   = '0;
      shift_nxt        = '0;
      status_acc_nxt   = '0;
      deadline_acc_nxt = '0;
      first_error_nxt  = rmfp_pkg::ERR_NONE;
    end else begin
      err_out = first_error_nxt;
    end
    res_nxt.error_code = err_out;

    if (!item_take) begin
      phase_nxt        = phase_r;
      bytes_left_nxt   = bytes_left_r;
      shift_nxt        = shift_r;
      status_acc_nxt   = status_acc_r;
      deadline_acc_nxt = deadline_acc_r;
      first_error_nxt  = first_error_r;
      res_nxt          = res_r;
    end else begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= rmfp_pkg::PH_SVC_LEN;
      bytes_left_r   <= '0;
      shift_r        <= '0;
      status_acc_r   <= '0;
      deadline_acc_r <= '0;
      first_error_r  <= rmfp_pkg::ERR_NONE;
      res_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      shift_r        <= shift_nxt;
      status_acc_r   <= status_acc_nxt;
      deadline_acc_r <= deadline_acc_nxt;
      first_error_r  <= first_error_nxt;
      res_valid_r    <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/rpc_meta_frame_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_meta_frame_parser_top: RPC metadata frame parser
// Takes one frame byte per request on the in_ stream and returns one tagged
// result per request on the out_ stream.
//
// in_tdata carries the byte, in_tuser says whether it is a frame byte and
// in_tlast marks the end of the frame buffer. Each result passes the byte
// through with its field tag in out_tuser; out_tlast marks the result that
// closes a frame, which also carries the error code, status and deadline.
// The cfg_ channel writes the byte order and the largest valid status; it is
// always ready and should be used only while the block is idle.
// A request is written into a queue slot and then into the output register
// once accepted; the parser takes one byte per cycle, so the block sustains one
// request per cycle while out_tready is high. A queue of QUEUE_DEPTH entries
// sits in front of the parser, so that many requests are still taken while a
// result waits. When the receiver stalls, the result holds and the queue fills;
// in_tready drops only once the queue is full. Reset empties the queue, drops
// out_tvalid, restores the register defaults and starts a fresh frame.
// ----------------------------------------------------------------------------
module rpc_meta_frame_parser_top #(
  parameter int unsigned QUEUE_DEPTH = rmfp_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // in_tdata: [7:0] data_byte
  input  wire logic [7:0]                          in_tdata,
  // in_tuser: [0] byte_valid
  input  wire logic                                in_tuser,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // out_tdata: [7:0] out_byte, [10:8] error_code, [18:11] status_value,
  // [82:19] deadline_value, [87:83] zero
  output logic [rmfp_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // out_tuser: [2:0] field_tag
  output logic [2:0]                               out_tuser,
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rmfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rmfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rmfp_pkg::cfg_t      cfg_r, cfg_nxt;
  rmfp_pkg::in_item_t  in_item;
  rmfp_pkg::in_item_t  head_item;
  rmfp_pkg::out_item_t res;
  logic q_full, q_empty, item_take;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        rmfp_pkg::REG_BIG_ENDIAN: cfg_nxt.big_endian = cfg_data[0];
        rmfp_pkg::REG_MAX_STATUS: cfg_nxt.max_status = cfg_data[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.big_endian <= rmfp_pkg::BIG_ENDIAN_RESET;
      cfg_r.max_status <= rmfp_pkg::MAX_STATUS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item.data_byte  = in_tdata;
  assign in_item.byte_valid = in_tuser;
  assign in_item.frame_end  = in_tlast;
  assign in_tready          = !q_full;

  rmfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid),
    .push_item(in_item),
    .full     (q_full),
    .pop      (item_take),
    .head_item(head_item),
    .empty    (q_empty)
  );

  rmfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item_avail(!q_empty),
    .item      (head_item),
    .item_take (item_take),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {5'd0, res.deadline_value, res.status_value, res.error_code,
                      res.out_byte};
  assign out_tuser = res.field_tag;
  assign out_tlast = res.frame_done;

endmodule
`default_nettype wire
